### design/wfg_pkg.sv
// Shared types and constants for the wait-for graph cycle detector.
// No dependencies; imported by wfg_ctrl, wfg_datapath and the top level.
package wfg_pkg;

  // Graph size and derived widths
  localparam int NODES       = 8;
  localparam int NODE_W      = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DEPTH_W     = $clog2(NODES + 1);
  localparam int MAX_RESULTS = 36;

  // Fixed field widths of the transaction payloads
  localparam int NODE_FW = 3;
  localparam int MASK_FW = 8;
  localparam int IDX_FW  = 6;

  // Node colors during the walk
  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_GREY  = 2'd1;
  localparam logic [1:0] COLOR_BLACK = 2'd2;

  // Request codes
  localparam logic REQ_ADD_EDGE = 1'b0;
  localparam logic REQ_DETECT   = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [NODE_FW-1:0] from_node;
    logic [NODE_FW-1:0] to_node;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [NODE_FW-1:0] waiting_node;
    logic [NODE_FW-1:0] closing_node;
    logic [MASK_FW-1:0] member_mask;
    logic [IDX_FW-1:0]  cycle_index;
    logic               last;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic add_edge;
    logic init;
    logic root_step;
    logic walk_step;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic root_end;
    logic root_white;
    logic depth_zero;
  } status_t;

endpackage

### design/wait_for_graph_cycle_detector.sv
// Wait-for graph deadlock detector: edge transactions leave busy low.
// A detect transaction holds busy through the depth-first walk, which tests one adjacency
// bit per cycle except in cycles that pop a node or start the walk from a new root.
// Cycle reports are strobed for one cycle during the walk; the final one (or the
// no-deadlock verdict) comes with last set as busy drops. Synchronous reset
// clears the graph, the colors and the controller.
module wait_for_graph_cycle_detector
  import wfg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    req,
  output logic    busy,
  output logic    result_valid,
  output result_t result
);

  cmd_t    cmd;
  status_t status;

  wfg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  wfg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req          (req),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

`ifndef ASSERT_OFF
  // An edge transaction never makes the block busy
  a_edge_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type == REQ_ADD_EDGE) |=> !busy)
    else $error("edge transaction raised busy");

  // The final result of a run arrives as the block goes idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("last result while still busy");

  // Results other than the final one appear only while walking
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> busy)
    else $error("non-final result outside a run");

  // The walk path is empty whenever the block is idle
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> status.depth_zero)
    else $error("walk stack not empty while idle");
`endif

endmodule

### design/wfg_ctrl.sv
// Controller state machine for the wait-for graph cycle detector.
// Depends on wfg_pkg; drives cmd_t to wfg_datapath and reads status_t.
module wfg_ctrl
  import wfg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    req_type,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ROOT = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_DETECT) begin
            cmd.init   = 1'b1;
            state_next = S_ROOT;
          end else begin
            cmd.add_edge = 1'b1;
          end
        end
      end
      S_ROOT: begin
        if (status.root_end) begin
          state_next = S_DONE;
        end else begin
          cmd.root_step = 1'b1;
          if (status.root_white) begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (status.depth_zero) begin
          state_next = S_ROOT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/wfg_datapath.sv
// Datapath of the wait-for graph cycle detector: adjacency matrix, colors,
// walk stack, pending result and output register. Depends on wfg_pkg.
module wfg_datapath
  import wfg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  req_t    req,
  output status_t status,
  output logic    result_valid,
  output result_t result
);

  logic [NODES-1:0]   adj   [NODES];
  logic [1:0]         color [NODES];
  logic [NODE_W-1:0]  stk   [NODES];
  logic [DEPTH_W-1:0] nxt   [NODES];
  logic [NODE_W-1:0]  pos   [NODES];
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] root;
  logic [IDX_FW-1:0]  cnt;
  logic               pend_valid;
  result_t            pend;

  logic [NODE_W-1:0]  top_idx;
  logic [NODE_W-1:0]  depth_idx;
  logic [NODE_W-1:0]  root_idx;
  logic [NODE_W-1:0]  u;
  logic [DEPTH_W-1:0] nv;
  logic [NODE_W-1:0]  v;
  logic               v_end;
  logic               edge_bit;
  logic [1:0]         vcol;
  logic               can_push;
  logic               is_cycle;
  logic               can_report;
  logic [NODES-1:0]   cyc_mask;
  logic               edge_ok;
  logic               report_now;
  result_t            final_res;

  // Walk step operands
  assign top_idx   = NODE_W'(depth - 1'b1);
  assign depth_idx = NODE_W'(depth);
  assign root_idx  = NODE_W'(root);
  assign u         = stk[top_idx];
  assign nv        = nxt[top_idx];
  assign v_end     = (32'(nv) >= NODES);
  assign v         = NODE_W'(nv);
  assign edge_bit  = adj[u][v];
  assign vcol      = color[v];
  assign can_push  = edge_bit && (vcol == COLOR_WHITE) && (32'(depth) < NODES);
  assign is_cycle  = edge_bit && (vcol == COLOR_GREY);
  assign can_report = (32'(cnt) < MAX_RESULTS);
  assign edge_ok   = (32'(req.from_node) < NODES) && (32'(req.to_node) < NODES);

  // A back edge that is reported in this walk step
  assign report_now = cmd.walk_step && !v_end && !can_push && is_cycle && can_report;

  // Cycle members: path nodes at or above the closing node's path position
  always_comb begin
    for (int n = 0; n < NODES; n++) begin
      cyc_mask[n] = (color[n] == COLOR_GREY) && (pos[n] >= pos[v]);
    end
  end

  // Final result of the run: the held cycle report, or the no-deadlock verdict
  always_comb begin
    final_res      = pend_valid ? pend : '0;
    final_res.last = 1'b1;
  end

  assign status.root_end   = (32'(root) == NODES);
  assign status.root_white = (color[root_idx] == COLOR_WHITE);
  assign status.depth_zero = (depth == '0);

  // Control state: graph, colors, depth, counters, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NODES; n++) begin
        adj[n]   <= '0;
        color[n] <= COLOR_WHITE;
      end
      depth        <= '0;
      root         <= '0;
      cnt          <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish || (report_now && pend_valid);
      if (cmd.add_edge && edge_ok) begin
        adj[NODE_W'(req.from_node)][NODE_W'(req.to_node)] <= 1'b1;
      end
      if (cmd.init) begin
        depth      <= '0;
        root       <= '0;
        cnt        <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.root_step) begin
        root <= root + 1'b1;
        if (status.root_white) begin
          color[root_idx] <= COLOR_GREY;
          depth           <= depth + 1'b1;
        end
      end
      if (cmd.walk_step) begin
        if (v_end) begin
          color[u] <= COLOR_BLACK;
          depth    <= depth - 1'b1;
        end else if (can_push) begin
          color[v] <= COLOR_GREY;
          depth    <= depth + 1'b1;
        end else if (is_cycle) begin
          // Drop the back edge; hold the new result until the next is known
          adj[u][v] <= 1'b0;
          if (can_report) begin
            cnt        <= cnt + 1'b1;
            pend_valid <= 1'b1;
          end
        end
      end
      if (cmd.finish) begin
        for (int n = 0; n < NODES; n++) begin
          color[n] <= COLOR_WHITE;
        end
        pend_valid <= 1'b0;
      end
    end
  end

  // Payload: stack entries, path positions, pending and output results
  always_ff @(posedge clk) begin
    if (cmd.root_step && status.root_white) begin
      stk[0]        <= root_idx;
      nxt[0]        <= '0;
      pos[root_idx] <= '0;
    end
    if (cmd.walk_step && !v_end) begin
      nxt[top_idx] <= nv + 1'b1;
      if (can_push) begin
        stk[depth_idx] <= v;
        nxt[depth_idx] <= '0;
        pos[v]         <= depth_idx;
      end else if (is_cycle && can_report) begin
        result              <= pend;
        pend.found          <= 1'b1;
        pend.waiting_node   <= NODE_FW'(u);
        pend.closing_node   <= NODE_FW'(v);
        pend.member_mask    <= MASK_FW'(cyc_mask);
        pend.cycle_index    <= cnt + 1'b1;
        pend.last           <= 1'b0;
      end
    end
    if (cmd.finish) begin
      result <= final_res;
    end
  end

endmodule
